>>> src/m3acc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 accumulator matrix ALU.
// No dependencies; imported by every module of the block.
package m3acc_pkg;

	localparam int MAT_DIM   = 3;
	localparam int MAT_CELLS = 9;
	localparam int ELEM_W    = 32;
	localparam int IDX_W     = 4;
	localparam int MODE_W    = 3;
	localparam int MAT_W     = MAT_CELLS * ELEM_W;

	// stream payload widths, padded to whole bytes
	localparam int S_TDATA_W = ((MAT_W + ELEM_W + IDX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((MAT_W + ELEM_W + 7) / 8) * 8;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef elem_t [MAT_CELLS-1:0] mat_t;   // row major, r0c0 in the low bits
	typedef elem_t [MAT_DIM-1:0] vec_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD  = 3'd0,
		MODE_ADD   = 3'd1,
		MODE_SUB   = 3'd2,
		MODE_RMUL  = 3'd3,
		MODE_SCALE = 3'd4,
		MODE_DIAG  = 3'd5,
		MODE_READ  = 3'd6,
		MODE_WRITE = 3'd7
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		mat_t             m;
		elem_t            scalar;
		logic [IDX_W-1:0] idx;
	} item_t;

	typedef struct packed {
		logic  index_error;
		elem_t read_value;
		mat_t  acc;
	} result_t;

endpackage

>>> src/m3acc_dot.sv
`timescale 1ns / 1ps
// Three-term signed dot product with floor shift and 32-bit saturation.
// Depends on m3acc_pkg.
module m3acc_dot import m3acc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  vec_t  a,
	input  vec_t  b,
	output elem_t y
);

	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W  = PROD_W + 2;

	logic signed [PROD_W-1:0]  prod [MAT_DIM];
	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   shifted;
	logic [SUM_W-ELEM_W:0]     hi;

	always_comb begin
		sum = '0;
		for (int j = 0; j < MAT_DIM; j++) begin
			prod[j] = PROD_W'($signed(a[j])) * PROD_W'($signed(b[j]));
			sum = sum + SUM_W'(prod[j]);
		end
		// arithmetic shift is floor for negative sums
		shifted = sum >>> FRAC_BITS;
		hi = shifted[SUM_W-1:ELEM_W-1];
		if (&hi || ~|hi) begin
			y = shifted[ELEM_W-1:0];
		end else if (shifted[SUM_W-1]) begin
			y = {1'b1, {(ELEM_W-1){1'b0}}};
		end else begin
			y = {1'b0, {(ELEM_W-1){1'b1}}};
		end
	end

endmodule

>>> src/m3acc_alu.sv
`timescale 1ns / 1ps
// Combinational next-state logic: computes the accumulator after one item,
// the read value and the index error. Depends on m3acc_pkg and m3acc_dot.
module m3acc_alu import m3acc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  mat_t    acc,
	input  item_t   item,
	output result_t res
);

	localparam int WIDE_W = ELEM_W + 1;

	mat_t dot_y;
	logic idx_ok;

	function automatic elem_t sat_addsub(input elem_t x, input elem_t y, input logic sub);
		logic signed [WIDE_W-1:0] s;
		begin
			s = sub ? (WIDE_W'(x) - WIDE_W'(y)) : (WIDE_W'(x) + WIDE_W'(y));
			if (s[WIDE_W-1] == s[WIDE_W-2]) begin
				sat_addsub = s[ELEM_W-1:0];
			end else if (s[WIDE_W-1]) begin
				sat_addsub = {1'b1, {(ELEM_W-1){1'b0}}};
			end else begin
				sat_addsub = {1'b0, {(ELEM_W-1){1'b1}}};
			end
		end
	endfunction

	// one dot unit per cell; scale uses lane 0 only
	for (genvar k = 0; k < MAT_CELLS; k++) begin : g_cell
		localparam int R = k / MAT_DIM;
		localparam int C = k % MAT_DIM;
		vec_t op_a;
		vec_t op_b;

		always_comb begin
			for (int j = 0; j < MAT_DIM; j++) begin
				if (item.mode == MODE_RMUL) begin
					op_a[j] = acc[R*MAT_DIM + j];
					op_b[j] = item.m[j*MAT_DIM + C];
				end else if (j == 0) begin
					op_a[j] = acc[k];
					op_b[j] = item.scalar;
				end else begin
					op_a[j] = '0;
					op_b[j] = '0;
				end
			end
		end

		m3acc_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
			.a(op_a),
			.b(op_b),
			.y(dot_y[k])
		);
	end

	always_comb begin
		idx_ok = item.idx < IDX_W'(MAT_CELLS);
		res.acc = acc;
		res.read_value = '0;
		res.index_error = 1'b0;
		unique case (item.mode)
			MODE_LOAD: begin
				res.acc = item.m;
			end
			MODE_ADD: begin
				for (int k = 0; k < MAT_CELLS; k++)
					res.acc[k] = sat_addsub(acc[k], item.m[k], 1'b0);
			end
			MODE_SUB: begin
				for (int k = 0; k < MAT_CELLS; k++)
					res.acc[k] = sat_addsub(acc[k], item.m[k], 1'b1);
			end
			MODE_RMUL, MODE_SCALE: begin
				res.acc = dot_y;
			end
			MODE_DIAG: begin
				for (int d = 0; d < MAT_DIM; d++)
					res.acc[d*(MAT_DIM+1)] = item.m[d*(MAT_DIM+1)];
			end
			MODE_READ: begin
				if (idx_ok) res.read_value = acc[item.idx];
				else res.index_error = 1'b1;
			end
			MODE_WRITE: begin
				if (idx_ok) begin
					for (int k = 0; k < MAT_CELLS; k++)
						if (IDX_W'(k) == item.idx) res.acc[k] = item.scalar;
				end else begin
					res.index_error = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> src/matrix3x3_accumulator_alu.sv
`timescale 1ns / 1ps
// Top level of the 3x3 Q16.16 accumulator matrix ALU.
// Depends on m3acc_pkg and m3acc_alu.

// The block takes one transaction per clock while the output is not stalled and
// returns one result per transaction; each passes through the input register and
// then the result register. The accumulator is updated as a result moves
// into the result register, so the loop that sets the cycle time is the
// accumulator feedback through the 27 parallel 32x32 multipliers, the
// three-term sum, the floor shift and the saturation. While a result waits,
// one more transaction is taken into the empty input register; after that the
// input stalls until the waiting result is taken.
// The accumulator resets to all zeros.
module matrix3x3_accumulator_alu import m3acc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// in_r0c0, in_r0c1, ... in_r2c2, scalar_value, element_index, zero pad
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// mode
	input  logic [MODE_W-1:0]    s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// acc_r0c0, acc_r0c1, ... acc_r2c2, read_value
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// index_error
	output logic                 m_axis_tuser
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	mat_t    acc_q;
	result_t res;
	logic    advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.mode   <= mode_t'(s_axis_tuser);
			item_s1.m      <= s_axis_tdata[MAT_W-1:0];
			item_s1.scalar <= s_axis_tdata[MAT_W+ELEM_W-1:MAT_W];
			item_s1.idx    <= s_axis_tdata[MAT_W+ELEM_W+IDX_W-1:MAT_W+ELEM_W];
		end
	end

	m3acc_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
		.acc (acc_q),
		.item(item_s1),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			acc_q       <= res.acc;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q.read_value, res_q.acc};
	assign m_axis_tuser  = res_q.index_error;

	// shown result always matches the live accumulator
	a_out_matches_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.acc == acc_q)
		else $error("result register out of step with accumulator");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(acc_q))
		else $error("accumulator changed without a transaction");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.mode == MODE_LOAD |=> acc_q == $past(item_s1.m))
		else $error("load did not copy the operand matrix");

	a_err_modes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.mode != MODE_READ && item_s1.mode != MODE_WRITE
		|=> !res_q.index_error && res_q.read_value == '0)
		else $error("index error or read value outside read/write modes");

endmodule

>>> tb/m3acc_result_check.sv
`timescale 1ns / 1ps
// Result checker for the 3x3 accumulator matrix ALU: watches both stream channels,
// keeps its own accumulator copy and compares every result transaction.
// Depends on m3acc_pkg.
module m3acc_result_check import m3acc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic [MODE_W-1:0]    s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [M_TDATA_W-1:0] m_axis_tdata,
	input  logic                 m_axis_tuser,
	output int                   mismatches,
	output int                   outstanding,
	output int                   results_seen
);

	localparam int WIDE = 68;
	typedef logic signed [WIDE-1:0] wide_t;

	result_t expected_acc_q[$];
	mat_t    acc_copy = '0;
	result_t next_res;
	result_t oldest;
	result_t got;
	int      fail_cnt = 0;
	int      seen_cnt = 0;
	int      fail_pub = 0;
	int      pend_pub = 0;
	int      seen_pub = 0;

	assign mismatches   = fail_pub;
	assign outstanding  = pend_pub;
	assign results_seen = seen_pub;

	function automatic elem_t clamp(wide_t v);
		if (v[WIDE-1:ELEM_W-1] == {(WIDE-ELEM_W+1){v[WIDE-1]}})
			return elem_t'(v[ELEM_W-1:0]);
		return v[WIDE-1] ? elem_t'({1'b1, {(ELEM_W-1){1'b0}}})
		                 : elem_t'({1'b0, {(ELEM_W-1){1'b1}}});
	endfunction

	// new accumulator, read value and error flag for one transaction
	function automatic result_t step_matrix(mat_t cur, mode_t op, mat_t m, elem_t sc,
	                                        logic [IDX_W-1:0] ix);
		result_t res;
		wide_t   total;
		wide_t   lhs;
		wide_t   rhs;
		int      r;
		int      c;
		int      j;
		int      k;
		res.acc         = cur;
		res.read_value  = '0;
		res.index_error = 1'b0;
		case (op)
			MODE_LOAD: res.acc = m;
			MODE_ADD: begin
				for (k = 0; k < MAT_CELLS; k++)
					res.acc[k] = clamp(wide_t'(cur[k]) + wide_t'(m[k]));
			end
			MODE_SUB: begin
				for (k = 0; k < MAT_CELLS; k++)
					res.acc[k] = clamp(wide_t'(cur[k]) - wide_t'(m[k]));
			end
			MODE_RMUL: begin
				// every term uses the accumulator from before the transaction
				for (r = 0; r < MAT_DIM; r++) begin
					for (c = 0; c < MAT_DIM; c++) begin
						total = '0;
						for (j = 0; j < MAT_DIM; j++) begin
							lhs   = cur[r*MAT_DIM+j];
							rhs   = m[j*MAT_DIM+c];
							total = total + lhs * rhs;
						end
						res.acc[r*MAT_DIM+c] = clamp(total >>> FRAC_BITS);
					end
				end
			end
			MODE_SCALE: begin
				for (k = 0; k < MAT_CELLS; k++) begin
					lhs        = cur[k];
					rhs        = sc;
					res.acc[k] = clamp((lhs * rhs) >>> FRAC_BITS);
				end
			end
			MODE_DIAG: begin
				for (k = 0; k < MAT_DIM; k++)
					res.acc[k*(MAT_DIM+1)] = m[k*(MAT_DIM+1)];
			end
			MODE_READ: begin
				if (ix < MAT_CELLS)
					res.read_value = cur[ix];
				else
					res.index_error = 1'b1;
			end
			MODE_WRITE: begin
				if (ix < MAT_CELLS)
					res.acc[ix] = sc;
				else
					res.index_error = 1'b1;
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_copy = '0;
			expected_acc_q.delete();
		end else begin
			// push before pop: the block never returns a result in the accept cycle
			if (s_axis_tvalid && s_axis_tready) begin
				next_res = step_matrix(acc_copy, mode_t'(s_axis_tuser), s_axis_tdata[MAT_W-1:0],
				                       s_axis_tdata[MAT_W +: ELEM_W],
				                       s_axis_tdata[MAT_W+ELEM_W +: IDX_W]);
				acc_copy = next_res.acc;
				expected_acc_q.push_back(next_res);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.acc         = m_axis_tdata[MAT_W-1:0];
				got.read_value  = m_axis_tdata[MAT_W +: ELEM_W];
				got.index_error = m_axis_tuser;
				seen_cnt++;
				if (expected_acc_q.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_cnt++;
				end else begin
					oldest = expected_acc_q.pop_front();
					for (int k = 0; k < MAT_CELLS; k++) begin
						if (got.acc[k] !== oldest.acc[k]) begin
							$error("acc_r%0dc%0d: expected %h, got %h", k / MAT_DIM, k % MAT_DIM,
							       oldest.acc[k], got.acc[k]);
							fail_cnt++;
						end
					end
					if (got.read_value !== oldest.read_value) begin
						$error("read_value: expected %h, got %h", oldest.read_value,
						       got.read_value);
						fail_cnt++;
					end
					if (got.index_error !== oldest.index_error) begin
						$error("index_error: expected %b, got %b", oldest.index_error,
						       got.index_error);
						fail_cnt++;
					end
				end
			end
		end
		fail_pub <= fail_cnt;
		pend_pub <= expected_acc_q.size();
		seen_pub <= seen_cnt;
	end

endmodule

>>> tb/matrix3x3_accumulator_alu_test.sv
`timescale 1ns / 1ps
// Top of the 3x3 accumulator matrix ALU testbench: clock, reset, stimulus and verdict.
// Depends on m3acc_pkg, matrix3x3_accumulator_alu and m3acc_result_check.
module matrix3x3_accumulator_alu_test;
	import m3acc_pkg::*;

	localparam int    FRAC_BITS    = 16;
	localparam int    RANDOM_ITEMS = 400;
	localparam int    CYCLE_LIMIT  = 100000;
	localparam int    PAD_W        = S_TDATA_W - MAT_W - ELEM_W - IDX_W;
	localparam elem_t E_MAX        = 32'sh7FFF_FFFF;
	localparam elem_t E_MIN        = 32'sh8000_0000;
	localparam elem_t ONE          = 32'sh0001_0000;
	localparam elem_t NEG_ONE      = 32'shFFFF_0000;
	localparam elem_t HALF         = 32'sh0000_8000;
	localparam elem_t NEG_HALF     = 32'shFFFF_8000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [MODE_W-1:0]    s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tuser;

	int mismatches;
	int outstanding;
	int results_seen;
	int cycles = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;
	int rx_style = 0;
	int rx_left = 0;
	int burst_left = 0;
	bit steady = 1'b0;
	int mode_cnt[8];
	int bad_index_cnt = 0;

	matrix3x3_accumulator_alu #(.FRAC_BITS(FRAC_BITS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	m3acc_result_check #(.FRAC_BITS(FRAC_BITS)) acc_check (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk) cycles++;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver: random ready patterns, plus one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_req != hold_done) begin
				hold_done++;
				hold_left = 60;
				m_axis_tready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_style = $urandom_range(0, 3);
					rx_left  = $urandom_range(16, 80);
				end
				rx_left--;
				case (rx_style)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ~m_axis_tready;
				endcase
			end
		end
	end

	function automatic mat_t mat9(elem_t a0, elem_t a1, elem_t a2, elem_t a3, elem_t a4,
	                              elem_t a5, elem_t a6, elem_t a7, elem_t a8);
		return {a8, a7, a6, a5, a4, a3, a2, a1, a0};
	endfunction

	function automatic mat_t mat_fill(elem_t v);
		return mat9(v, v, v, v, v, v, v, v, v);
	endfunction

	// extremes, full-range words, or small Q16.16 values that keep products in range
	function automatic elem_t rand_elem(bit tame);
		int sel;
		int v;
		sel = $urandom_range(0, 11);
		v   = int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
		if (tame && sel < 9)
			return elem_t'(v);
		case (sel)
			0: return E_MAX;
			1: return E_MIN;
			2, 3, 4, 5: return elem_t'($urandom);
			default: return elem_t'(v);
		endcase
	endfunction

	task automatic send(mode_t md, mat_t m, elem_t sc, logic [IDX_W-1:0] ix);
		int gap;
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		s_axis_tdata  <= {{PAD_W{1'b0}}, ix, sc, m};
		s_axis_tuser  <= md;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		mode_cnt[md]++;
		if ((md == MODE_READ || md == MODE_WRITE) && ix >= MAT_CELLS)
			bad_index_cnt++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		mode_t            md;
		mat_t             m;
		elem_t            sc;
		logic [IDX_W-1:0] ix;
		bit               tame;
		case ($urandom_range(0, 15))
			0, 1: md = MODE_LOAD;
			2, 3: md = MODE_ADD;
			4, 5: md = MODE_SUB;
			6, 7: md = MODE_RMUL;
			8, 9: md = MODE_SCALE;
			10: md = MODE_DIAG;
			11, 12: md = MODE_READ;
			default: md = MODE_WRITE;
		endcase
		tame = (md == MODE_RMUL || md == MODE_SCALE) && ($urandom_range(0, 3) != 0);
		for (int k = 0; k < MAT_CELLS; k++)
			m[k] = rand_elem(tame);
		sc = ($urandom_range(0, 3) == 0) ? ONE : rand_elem(tame);
		ix = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(9, 15))
		                                 : IDX_W'($urandom_range(0, 8));
		send(md, m, sc, ix);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset contents, saturation both ways, floor rounding, bad indexes
		send(MODE_READ, mat_fill(E_MAX), E_MAX, 4'd0);
		send(MODE_LOAD, mat9(E_MAX, E_MIN, 0, -1, ONE, NEG_ONE, 1, HALF, E_MAX), E_MIN, 4'd15);
		send(MODE_ADD, mat_fill(E_MAX), 0, 4'd15);
		send(MODE_SUB, mat_fill(E_MIN), 0, 4'd9);
		send(MODE_LOAD, mat_fill(E_MIN), 0, 4'd0);
		send(MODE_SUB, mat_fill(E_MAX), 0, 4'd0);
		send(MODE_LOAD, mat9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 0, 4'd0);
		send(MODE_RMUL, mat9(ONE + ONE, NEG_HALF, 3, -3, NEG_ONE, 32'sh0003_8001, -1, 7,
		                     NEG_HALF - 1), 0, 4'd0);
		send(MODE_RMUL, mat9(NEG_HALF, 5, -5, HALF + 1, -1, 1, ONE, NEG_ONE, 32'sh0000_4001),
		     0, 4'd0);
		send(MODE_RMUL, mat_fill(E_MAX), 0, 4'd0);
		send(MODE_RMUL, mat_fill(E_MIN), 0, 4'd0);
		send(MODE_LOAD, mat9(3, -3, ONE + 1, -ONE - 1, E_MAX, E_MIN, HALF, NEG_HALF, 1),
		     0, 4'd0);
		send(MODE_SCALE, '0, ONE, 4'd0);
		send(MODE_SCALE, '0, HALF, 4'd0);
		send(MODE_SCALE, '0, NEG_ONE, 4'd0);
		send(MODE_SCALE, '0, E_MAX, 4'd0);
		send(MODE_SCALE, '0, E_MIN, 4'd0);
		send(MODE_DIAG, mat9(E_MIN, E_MAX, E_MAX, E_MAX, -1, E_MAX, E_MAX, E_MAX, E_MAX),
		     E_MAX, 4'd15);
		send(MODE_READ, '0, 0, 4'd4);
		send(MODE_READ, '0, 0, 4'd8);
		send(MODE_READ, '0, 0, 4'd9);
		send(MODE_WRITE, '0, E_MAX, 4'd0);
		send(MODE_WRITE, '0, E_MIN, 4'd8);
		send(MODE_WRITE, '0, E_MAX, 4'd15);
		send(MODE_SCALE, '0, 0, 4'd0);
		drain();

		// long output hold while the input keeps offering back to back
		hold_req <= hold_req + 1;
		steady = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 40)
				steady = 1'b0;
			if (n == RANDOM_ITEMS / 2)
				drain();
			send_random();
		end
		drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d transactions: load %0d, add %0d, sub %0d, rmul %0d, scale %0d,",
		         mode_cnt.sum(), mode_cnt[MODE_LOAD], mode_cnt[MODE_ADD], mode_cnt[MODE_SUB],
		         mode_cnt[MODE_RMUL], mode_cnt[MODE_SCALE]);
		$display("diag %0d, read %0d, write %0d; %0d bad indexes, %0d results compared",
		         mode_cnt[MODE_DIAG], mode_cnt[MODE_READ], mode_cnt[MODE_WRITE], bad_index_cnt,
		         results_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
src/m3acc_pkg.sv
src/m3acc_dot.sv
src/m3acc_alu.sv
src/matrix3x3_accumulator_alu.sv
tb/m3acc_result_check.sv
tb/matrix3x3_accumulator_alu_test.sv
